[src/i2c_master_bit_engine_top_defines.svh]
// Assertion macros shared by the I2C master bit engine RTL.
// No dependencies; expects signals clk and rst_n in the using module.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define I2CM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/i2cm_pkg.sv]
// Shared types, codes and constants for the I2C master bit engine.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 16'd250;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WAIT  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_WAIT_ACK,
    CMD_READ
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_STOP,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_WA_HIGH,
    PH_WA_POLL,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_RA_LOW,
    PH_RA_HIGH
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_failed;
  } out_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

[src/i2cm_front.sv]
// Front end: accept ticks and decode the opcode into a command.
// Depends on i2cm_pkg.
module i2cm_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cm_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output i2cm_pkg::tick_t   q_entry
);
  import i2cm_pkg::*;

  cmd_t cmd;

  always_comb begin
    unique case (in_data.opcode)
      OP_START: cmd = CMD_START;
      OP_STOP:  cmd = CMD_STOP;
      OP_WRITE: cmd = CMD_WRITE;
      OP_WAIT:  cmd = CMD_WAIT_ACK;
      OP_READ:  cmd = CMD_READ;
      default:  cmd = CMD_NONE;
    endcase
  end

  assign in_ready          = !q_full;
  assign q_push            = in_valid && !q_full;
  assign q_entry.cmd       = cmd;
  assign q_entry.data_byte = in_data.data_byte;
  assign q_entry.send_ack  = in_data.send_ack;
  assign q_entry.sda_in    = in_data.sda_in;

endmodule

[src/i2cm_queue.sv]
// Two-entry queue of decoded ticks between front and back end.
// Depends on i2cm_pkg and the assertion macro header.
`include "i2c_master_bit_engine_top_defines.svh"
module i2cm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cm_pkg::tick_t push_entry,
  output logic            full,
  output logic            q_valid,
  output i2cm_pkg::tick_t q_entry,
  input  logic            pop
);
  import i2cm_pkg::*;

  tick_t      mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full    = count_r[1];
  assign q_valid = (count_r != 2'd0);
  assign q_entry = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `I2CM_ASSERT_CLK(a_count_range, count_r != 2'd3, "queue count out of range")
  `I2CM_ASSERT_CLK(a_no_overflow, full |-> !push, "push into full queue")
  `I2CM_ASSERT_CLK(a_ptr_gap, (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r),
                   "queue pointers disagree with count")

endmodule

[src/i2cm_back.sv]
// Back end: bus phase sequencer, timing counters, config registers, result register.
// Depends on i2cm_pkg and the assertion macro header.
`include "i2c_master_bit_engine_top_defines.svh"
module i2cm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        q_valid,
  input  i2cm_pkg::tick_t             q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output i2cm_pkg::out_item_t         out_data
);
  import i2cm_pkg::*;

  logic [CFG_W-1:0] half_r, tmo_lim_r;
  phase_t           phase_r, phase_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [3:0]       bit_idx_r, bit_idx_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [15:0]      tmo_r, tmo_nxt;
  logic             ack_mode_r, ack_mode_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             oe_r, oe_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             fail_r, fail_nxt;
  logic             done_nxt;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [15:0] half_eff;
  logic [15:0] delay_dec;
  logic        fire;
  logic [3:0]  bit_inc;
  logic [7:0]  rd_sample;
  logic        tmo_hit;

  assign half_eff  = (half_r == '0) ? 16'd1 : half_r;
  assign delay_dec = (delay_r != '0) ? delay_r - 16'd1 : 16'd0;
  assign fire      = (delay_dec == '0);
  assign bit_inc   = bit_idx_r + 4'd1;
  assign rd_sample = {shift_r[6:0], q_entry.sda_in};
  assign tmo_hit   = (tmo_r >= tmo_lim_r);

  // Take a tick whenever the result register is free or being drained.
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (q_entry.cmd)
          CMD_START:    phase_nxt = PH_START_A;
          CMD_STOP:     phase_nxt = PH_STOP;
          CMD_WRITE:    phase_nxt = PH_WR_LOW;
          CMD_WAIT_ACK: phase_nxt = PH_WA_HIGH;
          CMD_READ:     phase_nxt = PH_RD_LOW;
          default:      phase_nxt = PH_IDLE;
        endcase
      end
      PH_WA_POLL: begin
        if (!q_entry.sda_in) begin
          phase_nxt = PH_IDLE;
        end else if (tmo_hit) begin
          phase_nxt = PH_STOP;
        end
      end
      PH_START_A: if (fire) phase_nxt = PH_START_B;
      PH_START_B: if (fire) phase_nxt = PH_IDLE;
      PH_STOP:    if (fire) phase_nxt = PH_IDLE;
      PH_WR_LOW:  if (fire) phase_nxt = PH_WR_HIGH;
      PH_WR_HIGH: if (fire) phase_nxt = bit_inc[3] ? PH_IDLE : PH_WR_LOW;
      PH_WA_HIGH: if (fire) phase_nxt = PH_WA_POLL;
      PH_RD_LOW:  if (fire) phase_nxt = PH_RD_HIGH;
      PH_RD_HIGH: if (fire) phase_nxt = bit_inc[3] ? PH_RA_LOW : PH_RD_LOW;
      PH_RA_LOW:  if (fire) phase_nxt = PH_RA_HIGH;
      PH_RA_HIGH: if (fire) phase_nxt = PH_IDLE;
      default:    phase_nxt = PH_IDLE;
    endcase
  end

  // Line levels, counters and flags
  always_comb begin
    delay_nxt    = delay_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    tmo_nxt      = tmo_r;
    ack_mode_nxt = ack_mode_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    oe_nxt       = oe_r;
    rx_nxt       = rx_r;
    fail_nxt     = fail_r;
    done_nxt     = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        unique case (q_entry.cmd)
          CMD_START: begin
            {scl_nxt, sda_nxt, oe_nxt} = 3'b111;
            delay_nxt = half_eff;
          end
          CMD_STOP: begin
            {scl_nxt, sda_nxt, oe_nxt} = 3'b001;
            delay_nxt = half_eff;
          end
          CMD_WRITE: begin
            shift_nxt   = q_entry.data_byte;
            bit_idx_nxt = 4'd0;
            {scl_nxt, sda_nxt, oe_nxt} = {1'b0, q_entry.data_byte[7], 1'b1};
            delay_nxt = half_eff;
          end
          CMD_WAIT_ACK: begin
            tmo_nxt = 16'd0;
            {scl_nxt, sda_nxt, oe_nxt} = 3'b110;
            delay_nxt = half_eff;
          end
          CMD_READ: begin
            shift_nxt    = 8'd0;
            bit_idx_nxt  = 4'd0;
            ack_mode_nxt = q_entry.send_ack;
            {scl_nxt, sda_nxt, oe_nxt} = 3'b010;
            delay_nxt = half_eff;
          end
          default: ;
        endcase
      end
      PH_WA_POLL: begin
        if (!q_entry.sda_in) begin
          scl_nxt  = 1'b0;
          fail_nxt = 1'b0;
          done_nxt = 1'b1;
        end else if (tmo_hit) begin
          fail_nxt = 1'b1;
          {scl_nxt, sda_nxt, oe_nxt} = 3'b001;
          delay_nxt = half_eff;
        end else begin
          tmo_nxt = tmo_r + 16'd1;
        end
      end
      default: begin
        delay_nxt = delay_dec;
        if (fire) begin
          scl_nxt = 1'b1;
          unique case (phase_r)
            PH_START_A: begin
              sda_nxt   = 1'b0;
              delay_nxt = half_eff;
            end
            PH_START_B: begin
              scl_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
            PH_STOP: begin
              {scl_nxt, sda_nxt, oe_nxt} = 3'b111;
              done_nxt = 1'b1;
            end
            PH_WR_HIGH: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_idx_nxt = bit_inc;
              if (bit_inc[3]) begin
                done_nxt = 1'b1;
              end else begin
                sda_nxt   = shift_r[6];
                delay_nxt = half_eff;
              end
            end
            PH_RD_HIGH: begin
              scl_nxt     = 1'b0;
              shift_nxt   = rd_sample;
              bit_idx_nxt = bit_inc;
              delay_nxt   = half_eff;
              if (bit_inc[3]) begin
                rx_nxt = rd_sample;
                {scl_nxt, sda_nxt, oe_nxt} = {1'b0, !ack_mode_r, 1'b1};
              end
            end
            PH_RA_HIGH: begin
              scl_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
            PH_WA_HIGH: ;
            default: delay_nxt = half_eff;
          endcase
        end
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_PERIOD_RST;
      tmo_lim_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: half_r    <= cfg_wdata;
        CFG_ACK_TIMEOUT: tmo_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Engine state, advanced once per consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      delay_r    <= '0;
      bit_idx_r  <= '0;
      shift_r    <= '0;
      tmo_r      <= '0;
      ack_mode_r <= 1'b0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      oe_r       <= 1'b1;
      rx_r       <= '0;
      fail_r     <= 1'b0;
    end else if (q_pop) begin
      phase_r    <= phase_nxt;
      delay_r    <= delay_nxt;
      bit_idx_r  <= bit_idx_nxt;
      shift_r    <= shift_nxt;
      tmo_r      <= tmo_nxt;
      ack_mode_r <= ack_mode_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      oe_r       <= oe_nxt;
      rx_r       <= rx_nxt;
      fail_r     <= fail_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r.scl_level        <= scl_nxt;
      out_r.sda_level        <= !oe_nxt || sda_nxt;
      out_r.sda_drive_enable <= oe_nxt;
      out_r.busy_res         <= (phase_nxt != PH_IDLE);
      out_r.done_res         <= done_nxt;
      out_r.read_data        <= rx_nxt;
      out_r.ack_failed       <= fail_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `I2CM_ASSERT_CLK(a_busy_tracks_phase, q_pop |=> (out_r.busy_res == (phase_r != PH_IDLE)),
                   "busy flag disagrees with phase")
  `I2CM_ASSERT_CLK(a_bit_index_bound, bit_idx_r[3] |-> (bit_idx_r[2:0] == 3'd0),
                   "bit index past eight")
  `I2CM_ASSERT_CLK(a_timed_delay_loaded,
                   (phase_r != PH_IDLE && phase_r != PH_WA_POLL) |-> (delay_r != '0),
                   "timed phase with empty delay count")
  `I2CM_ASSERT_CLK(a_release_phases,
                   !oe_r |-> (phase_r == PH_IDLE || phase_r == PH_WA_HIGH ||
                              phase_r == PH_WA_POLL || phase_r == PH_RD_LOW ||
                              phase_r == PH_RD_HIGH),
                   "SDA released outside ack wait or read")

endmodule

[src/i2c_master_bit_engine_top.sv]
// Top level of the I2C master bit engine: front decoder, tick queue, back-end sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
// Each request on the in_ channel is one timing tick: an optional command (start, stop,
// write byte, wait for acknowledge, read byte with ACK/NACK) plus the sampled SDA level.
// Every request yields exactly one result on the out_ channel carrying the SCL/SDA levels,
// SDA drive enable, busy, a one-tick done pulse, the last received byte and the
// acknowledge-failure flag, all as they stand after that tick. Commands that arrive while
// busy are dropped, as are opcodes 6 and 7. Rate: one request per clock cycle sustained
// while out_ready is high; each request passes the queue, then the result register. The
// front end decodes the opcode and pushes into a two-entry queue; the back end pops one
// tick per cycle into the bus sequencer, whose single result register is the only
// throughput limiter, and it drains every cycle that out_ready is high. in_ready drops
// only when the queue is full, i.e. after out_ready has been held low. Half-bit timing
// and ack timeout come from cfg_ registers (index 0: half period in ticks, zero acts as
// one; index 1: ack timeout in ticks); write them only while no command is in flight.
module i2c_master_bit_engine_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  i2cm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output i2cm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_W-1:0]     cfg_wdata
);
  import i2cm_pkg::*;

  // Front-to-queue and queue-to-back handshakes
  logic  q_full;
  logic  q_push;
  tick_t push_entry;
  logic  q_valid;
  tick_t q_entry;
  logic  q_pop;

  // Decode the opcode; hold off new requests while the queue is full
  i2cm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // Absorb ticks while the result side stalls
  i2cm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .pop        (q_pop)
  );

  // Advance the bus sequencer one tick per popped entry and register its result
  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
